/* hw/rtl/pbpl_pkg.sv */
// ============================================================================
// Priority box point locator package
// Shared constants, types and helpers for the box locator blocks.
// ============================================================================
package pbpl_pkg;

  // Coordinate width of the query point and box corners (signed Q16.8).
  localparam int CoordW = 24;
  // Doubled centre offset min + max - 2 * point needs two more bits.
  localparam int DiffW = CoordW + 2;
  // Magnitude of that offset fits one bit less than the signed form.
  localparam int MagW = DiffW - 1;
  localparam int SqW = 2 * MagW;
  // Sum of three squares.
  localparam int DistW = SqW + 2;

  localparam int PrioW = 8;
  localparam int MaxEntries = 256;
  localparam int CountW = $clog2(MaxEntries);
  localparam int SectorW = 8;

  localparam int QueueDepth = 4;
  localparam int QPtrW = $clog2(QueueDepth);
  localparam int QCntW = $clog2(QueueDepth + 1);

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [DiffW-1:0] diff_t;
  typedef logic [MagW-1:0] mag_t;
  typedef logic [SqW-1:0] sq_t;
  typedef logic [DistW-1:0] dist_t;
  typedef logic signed [PrioW-1:0] prio_t;
  typedef logic [CountW-1:0] count_t;

  typedef enum logic [1:0] {
    ChoiceReal = 2'd0,
    ChoiceVirt = 2'd1,
    ChoiceLast = 2'd2
  } choice_e;

  // One classified entry, as the front hands it to the back.
  typedef struct packed {
    count_t         pos;
    logic           contained;
    logic           virt;
    logic           last;
    prio_t          prio;
    logic [2:0][MagW-1:0] mag;
  } entry_t;

  // Fill status of the queue between front and back.
  typedef struct packed {
    logic             empty;
    logic             full;
    logic [QCntW-1:0] count;
  } q_status_t;

  function automatic diff_t sext_coord(coord_t c);
    sext_coord = {{(DiffW - CoordW){c[CoordW-1]}}, c};
  endfunction

  // Low bits of an entry position, zero extended when the counter is narrow.
  function automatic logic [SectorW-1:0] to_sector(count_t c);
    to_sector = SectorW'(32'(c));
  endfunction

endpackage

/* hw/rtl/pbpl_if.sv */
// ============================================================================
// Box locator channel interfaces
// Valid/ready channels for box entries, results and the floor register.
// ============================================================================
interface pbpl_in_if;
  logic                  valid;
  logic                  ready;
  pbpl_pkg::coord_t      point_x;
  pbpl_pkg::coord_t      point_y;
  pbpl_pkg::coord_t      point_z;
  pbpl_pkg::coord_t      box_min_x;
  pbpl_pkg::coord_t      box_min_y;
  pbpl_pkg::coord_t      box_min_z;
  pbpl_pkg::coord_t      box_max_x;
  pbpl_pkg::coord_t      box_max_y;
  pbpl_pkg::coord_t      box_max_z;
  pbpl_pkg::prio_t       priority_req;
  logic                  is_virtual;
  logic                  last;

  modport source (
    output valid, point_x, point_y, point_z, box_min_x, box_min_y, box_min_z,
           box_max_x, box_max_y, box_max_z, priority_req, is_virtual, last,
    input  ready
  );
  modport sink (
    input  valid, point_x, point_y, point_z, box_min_x, box_min_y, box_min_z,
           box_max_x, box_max_y, box_max_z, priority_req, is_virtual, last,
    output ready
  );
endinterface

interface pbpl_out_if;
  logic                          valid;
  logic                          ready;
  logic [pbpl_pkg::SectorW-1:0]  sector_index;
  logic [1:0]                    choice;

  modport source (output valid, sector_index, choice, input ready);
  modport sink (input valid, sector_index, choice, output ready);
endinterface

interface pbpl_cfg_if;
  logic            valid;
  logic            ready;
  pbpl_pkg::prio_t data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

/* hw/rtl/pbpl_front.sv */
// ============================================================================
// Box locator front end
// Accepts box entries, tests containment, forms axis offsets and positions.
// ============================================================================
module pbpl_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  pbpl_in_if.sink             in_i,
  input  pbpl_pkg::q_status_t q_status_i,
  output logic                push_o,
  output pbpl_pkg::entry_t    push_entry_o
);

  logic             valid_q, valid_d;
  pbpl_pkg::entry_t entry_q, entry_d;
  pbpl_pkg::count_t cnt_q, cnt_d;
  logic             accept;
  logic             pushed;
  pbpl_pkg::diff_t  diff_x, diff_y, diff_z;

  assign pushed   = valid_q && !q_status_i.full;
  assign in_i.ready = !valid_q || !q_status_i.full;
  assign accept   = in_i.valid && in_i.ready;
  assign push_o   = valid_q;
  assign push_entry_o = entry_q;

  // Doubled offset of the box centre from the point on each axis.
  assign diff_x = pbpl_pkg::sext_coord(in_i.box_min_x) + pbpl_pkg::sext_coord(in_i.box_max_x)
                - (pbpl_pkg::sext_coord(in_i.point_x) <<< 1);
  assign diff_y = pbpl_pkg::sext_coord(in_i.box_min_y) + pbpl_pkg::sext_coord(in_i.box_max_y)
                - (pbpl_pkg::sext_coord(in_i.point_y) <<< 1);
  assign diff_z = pbpl_pkg::sext_coord(in_i.box_min_z) + pbpl_pkg::sext_coord(in_i.box_max_z)
                - (pbpl_pkg::sext_coord(in_i.point_z) <<< 1);

  always_comb begin
    entry_d.pos       = cnt_q;
    entry_d.contained = (in_i.point_x >= in_i.box_min_x) && (in_i.point_x <= in_i.box_max_x)
                     && (in_i.point_y >= in_i.box_min_y) && (in_i.point_y <= in_i.box_max_y)
                     && (in_i.point_z >= in_i.box_min_z) && (in_i.point_z <= in_i.box_max_z);
    entry_d.virt   = in_i.is_virtual;
    entry_d.last   = in_i.last;
    entry_d.prio   = in_i.priority_req;
    entry_d.mag[0] = pbpl_pkg::MagW'(diff_x[pbpl_pkg::DiffW-1] ? -diff_x : diff_x);
    entry_d.mag[1] = pbpl_pkg::MagW'(diff_y[pbpl_pkg::DiffW-1] ? -diff_y : diff_y);
    entry_d.mag[2] = pbpl_pkg::MagW'(diff_z[pbpl_pkg::DiffW-1] ? -diff_z : diff_z);
  end

  always_comb begin
    valid_d = valid_q;
    cnt_d   = cnt_q;
    if (pushed) begin
      valid_d = 1'b0;
    end
    if (accept) begin
      valid_d = 1'b1;
      if (in_i.last) begin
        cnt_d = '0;
      end else if (cnt_q != pbpl_pkg::CountW'(pbpl_pkg::MaxEntries - 1)) begin
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      valid_q <= valid_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      entry_q <= entry_d;
    end
  end

endmodule

/* hw/rtl/pbpl_queue.sv */
// ============================================================================
// Box locator entry queue
// Short queue of classified entries between the front and the back.
// ============================================================================
module pbpl_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  pbpl_pkg::entry_t    push_entry_i,
  input  logic                pop_i,
  output pbpl_pkg::entry_t    head_o,
  output pbpl_pkg::q_status_t status_o
);

  pbpl_pkg::entry_t mem_q [pbpl_pkg::QueueDepth];
  logic [pbpl_pkg::QPtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [pbpl_pkg::QCntW-1:0] cnt_q, cnt_d;
  logic do_push, do_pop;

  assign status_o.empty = (cnt_q == '0);
  assign status_o.full  = (cnt_q == pbpl_pkg::QCntW'(pbpl_pkg::QueueDepth));
  assign status_o.count = cnt_q;
  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == pbpl_pkg::QPtrW'(pbpl_pkg::QueueDepth - 1)) ? '0
               : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == pbpl_pkg::QPtrW'(pbpl_pkg::QueueDepth - 1)) ? '0
               : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

/* hw/rtl/pbpl_back.sv */
// ============================================================================
// Box locator back end
// Squares, sums and ranks entries, keeps both winners and reports per query.
// ============================================================================
module pbpl_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pbpl_pkg::prio_t     priority_floor_i,
  input  pbpl_pkg::entry_t    head_i,
  input  pbpl_pkg::q_status_t q_status_i,
  output logic                pop_o,
  output logic                stall_o,
  pbpl_out_if.source          out_o
);

  typedef struct packed {
    pbpl_pkg::count_t pos;
    logic             contained;
    logic             virt;
    logic             last;
    pbpl_pkg::prio_t  prio;
  } meta_t;

  logic stall, advance;

  // Square stage.
  logic                   s1_valid_q;
  meta_t                  s1_meta_q;
  logic [2:0][pbpl_pkg::SqW-1:0] s1_sq_q;
  // Sum stage.
  logic                   s2_valid_q;
  meta_t                  s2_meta_q;
  pbpl_pkg::dist_t        s2_dist_q;

  // Per-query search state.
  logic             fresh_q;
  logic             real_found_q, virt_found_q;
  pbpl_pkg::count_t real_idx_q, virt_idx_q;
  pbpl_pkg::prio_t  real_prio_q, virt_prio_q;
  pbpl_pkg::dist_t  real_dist_q, virt_dist_q;

  logic             real_found_e, virt_found_e;
  pbpl_pkg::prio_t  real_prio_e, virt_prio_e;
  logic             real_win, virt_win;
  logic             real_found_n, virt_found_n;
  pbpl_pkg::count_t real_idx_n, virt_idx_n;
  pbpl_pkg::prio_t  real_prio_n, virt_prio_n;
  pbpl_pkg::dist_t  real_dist_n, virt_dist_n;

  logic                          out_valid_q, out_valid_d;
  logic [pbpl_pkg::SectorW-1:0]  out_index_q, out_index_d;
  pbpl_pkg::choice_e             out_choice_q, out_choice_d;
  logic                          emit;

  assign stall   = out_valid_q && !out_o.ready;
  assign advance = !stall;
  assign pop_o   = advance && !q_status_i.empty;
  assign stall_o = stall;

  // The first entry of a query ranks against the floor, not stale winners.
  always_comb begin
    real_found_e = !fresh_q && real_found_q;
    virt_found_e = !fresh_q && virt_found_q;
    real_prio_e  = fresh_q ? priority_floor_i : real_prio_q;
    virt_prio_e  = fresh_q ? priority_floor_i : virt_prio_q;

    real_win = s2_meta_q.contained && !s2_meta_q.virt
            && (real_found_e ? ((s2_meta_q.prio > real_prio_e)
                                || ((s2_meta_q.prio == real_prio_e)
                                    && (s2_dist_q < real_dist_q)))
                             : (s2_meta_q.prio >= real_prio_e));
    virt_win = s2_meta_q.contained && s2_meta_q.virt
            && (virt_found_e ? ((s2_meta_q.prio > virt_prio_e)
                                || ((s2_meta_q.prio == virt_prio_e)
                                    && (s2_dist_q < virt_dist_q)))
                             : (s2_meta_q.prio >= virt_prio_e));

    real_found_n = real_found_e || real_win;
    virt_found_n = virt_found_e || virt_win;
    real_idx_n   = real_win ? s2_meta_q.pos : real_idx_q;
    virt_idx_n   = virt_win ? s2_meta_q.pos : virt_idx_q;
    real_prio_n  = real_win ? s2_meta_q.prio : real_prio_e;
    virt_prio_n  = virt_win ? s2_meta_q.prio : virt_prio_e;
    real_dist_n  = real_win ? s2_dist_q : real_dist_q;
    virt_dist_n  = virt_win ? s2_dist_q : virt_dist_q;
  end

  assign emit = advance && s2_valid_q && s2_meta_q.last;

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (emit) begin
      out_valid_d = 1'b1;
    end
    priority if (real_found_n) begin
      out_index_d  = pbpl_pkg::to_sector(real_idx_n);
      out_choice_d = pbpl_pkg::ChoiceReal;
    end else if (virt_found_n) begin
      out_index_d  = pbpl_pkg::to_sector(virt_idx_n);
      out_choice_d = pbpl_pkg::ChoiceVirt;
    end else begin
      out_index_d  = pbpl_pkg::to_sector(s2_meta_q.pos);
      out_choice_d = pbpl_pkg::ChoiceLast;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.sector_index = out_index_q;
  assign out_o.choice       = out_choice_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      s2_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      fresh_q      <= 1'b1;
      real_found_q <= 1'b0;
      virt_found_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (advance) begin
        s1_valid_q <= !q_status_i.empty;
        s2_valid_q <= s1_valid_q;
        if (s2_valid_q) begin
          fresh_q      <= s2_meta_q.last;
          real_found_q <= real_found_n;
          virt_found_q <= virt_found_n;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_meta_q.pos       <= head_i.pos;
      s1_meta_q.contained <= head_i.contained;
      s1_meta_q.virt      <= head_i.virt;
      s1_meta_q.last      <= head_i.last;
      s1_meta_q.prio      <= head_i.prio;
      for (int a = 0; a < 3; a++) begin
        s1_sq_q[a] <= head_i.mag[a] * head_i.mag[a];
      end
      s2_meta_q <= s1_meta_q;
      s2_dist_q <= pbpl_pkg::DistW'(s1_sq_q[0]) + pbpl_pkg::DistW'(s1_sq_q[1])
                 + pbpl_pkg::DistW'(s1_sq_q[2]);
      if (s2_valid_q) begin
        real_idx_q  <= real_idx_n;
        virt_idx_q  <= virt_idx_n;
        real_prio_q <= real_prio_n;
        virt_prio_q <= virt_prio_n;
        real_dist_q <= real_dist_n;
        virt_dist_q <= virt_dist_n;
      end
    end
    if (emit) begin
      out_index_q  <= out_index_d;
      out_choice_q <= out_choice_d;
    end
  end

endmodule

/* hw/rtl/priority_box_point_locator_unit.sv */
// ============================================================================
// Priority box point locator
// Picks the best real box containing a query point, else the best virtual one, else reports the last entry.
// ============================================================================
// Throughput: one box entry per cycle, sustained, as long as results are taken.
// A result passes from its last entry's transfer through the front register, the queue,
//   the square stage, the sum stage and the output register, in that order.
// The output register lets the back stall while the queue keeps absorbing entries.
// Reset: asynchronous and active low; it empties all stages and the queue,
//   starts a fresh query and sets the priority floor to -128.
module priority_box_point_locator_unit (
  input  logic     clk_i,
  input  logic     rst_ni,
  pbpl_in_if.sink  in_i,
  pbpl_cfg_if.sink cfg_i,
  pbpl_out_if.source out_o
);

  // The priority floor register. Both searches take it as their starting
  // priority when the first entry of a query reaches the ranking stage.
  pbpl_pkg::prio_t priority_floor_q;

  // Front to queue.
  logic                push;
  pbpl_pkg::entry_t    push_entry;
  // Queue to back.
  pbpl_pkg::entry_t    head;
  pbpl_pkg::q_status_t q_status;
  logic                pop;
  logic                back_stall;

  // Configuration writes are always accepted. The user must write only while the block
  // is idle, so no entry in flight sees a changing floor; the block does not enforce it.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      priority_floor_q <= -8'sd128;
    end else if (cfg_i.valid && cfg_i.ready) begin
      priority_floor_q <= cfg_i.data;
    end
  end

  // The front tests containment and forms the three doubled centre offsets,
  // then tags each entry with its saturating position within the query.
  pbpl_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .q_status_i   (q_status),
    .push_o       (push),
    .push_entry_o (push_entry)
  );

  // A short queue decouples the front from a stalled back end.
  pbpl_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .pop_i        (pop),
    .head_o       (head),
    .status_o     (q_status)
  );

  // The back squares the offsets, sums them into a distance, updates the
  // real and virtual winners, and on the last entry presents the result.
  pbpl_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .priority_floor_i (priority_floor_q),
    .head_i           (head),
    .q_status_i       (q_status),
    .pop_o            (pop),
    .stall_o          (back_stall),
    .out_o            (out_o)
  );

  // The front only refuses entries when it holds one the queue cannot take.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> q_status.full)
    else $error("front refused a transfer while the queue had room");

  // The queue never holds more than its depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_status.count <= pbpl_pkg::QCntW'(pbpl_pkg::QueueDepth))
    else $error("queue fill count exceeds its depth");

  // A stalled back end must not drain the queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_stall |-> !pop)
    else $error("queue popped while the back end was stalled");

  // A held result keeps its value until it is transferred.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |=> (out_o.valid && $stable(out_o.sector_index)
                                       && $stable(out_o.choice)))
    else $error("pending result changed before its transfer");

endmodule
